/* rtl/core/lbm_pkg.sv */
package lbm_pkg;

  localparam int FRACTION_BITS_DEF = 28;
  localparam int NUM_DIR = 9;
  localparam int WORD_W = 32;
  localparam int SUM_W = 36;
  localparam int RATE_W = 30;
  localparam int QUOT_W = 32;
  // prep stage + one stage per quotient bit + clamp stage
  localparam int LANE_LAT = QUOT_W + 2;

  localparam logic [RATE_W-1:0] RATE_RESET = 30'd268435456;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [NUM_DIR-1:0] dist_t;
  typedef logic signed [SUM_W-1:0] moment_t;

  typedef struct packed {
    dist_t f;
    word_t rho;
  } cell_t;

  function automatic word_t sat_word(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/lbm_d2q9_bgk_collision.sv */
// D2Q9 BGK collision kernel, one lattice cell per transaction.
// Pipeline stages: 2 moment stages, 34 per divider lane, 8 collision stages.
// Throughput: one cell per cycle while out_ready does not stall the pipeline;
// the divider runs one quotient bit per stage.
// Reset: rst is synchronous, active high; clears all valid bits and loads
// relax_rate with one (2^28). Datapath registers are not reset.
module lbm_d2q9_bgk_collision #(
  parameter int FRACTION_BITS = lbm_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [lbm_pkg::RATE_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         f_rest,
  input  logic signed [31:0]         f_east,
  input  logic signed [31:0]         f_north,
  input  logic signed [31:0]         f_west,
  input  logic signed [31:0]         f_south,
  input  logic signed [31:0]         f_northeast,
  input  logic signed [31:0]         f_northwest,
  input  logic signed [31:0]         f_southwest,
  input  logic signed [31:0]         f_southeast,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_rest,
  output logic signed [31:0]         out_east,
  output logic signed [31:0]         out_north,
  output logic signed [31:0]         out_west,
  output logic signed [31:0]         out_south,
  output logic signed [31:0]         out_northeast,
  output logic signed [31:0]         out_northwest,
  output logic signed [31:0]         out_southwest,
  output logic signed [31:0]         out_southeast,
  output logic signed [31:0]         density,
  output logic signed [31:0]         velocity_x,
  output logic signed [31:0]         velocity_y
);
  import lbm_pkg::*;

  // Whole pipeline advances together; the last collide stage is the
  // output register, so a held result freezes every stage behind it and
  // nothing is dropped or duplicated.
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // omega = 1/tau; the user must write it only while idle, the block does not enforce this
  logic [RATE_W-1:0] relax_rate;
  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate <= RATE_RESET;
    end else if (cfg_wr_en) begin
      relax_rate <= cfg_wr_data;
    end
  end

  dist_t f_in;
  assign f_in = {f_southeast, f_southwest, f_northwest, f_northeast,
                 f_south, f_west, f_north, f_east, f_rest};

  // moments: density, x and y momentum
  logic    m_valid;
  cell_t   m_cell;
  moment_t m_mx, m_my;

  lbm_moments u_moments (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid && in_ready), .f(f_in),
    .out_valid(m_valid), .out_cell(m_cell), .mx(m_mx), .my(m_my)
  );

  // velocity = momentum / density, two bit-per-stage divider lanes
  logic  v_valid;
  cell_t v_cell;
  word_t v_ux, v_uy;

  lbm_velocity #(.FRACTION_BITS(FRACTION_BITS)) u_velocity (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(m_valid), .in_cell(m_cell), .mx(m_mx), .my(m_my),
    .out_valid(v_valid), .out_cell(v_cell), .ux(v_ux), .uy(v_uy)
  );

  // equilibrium and BGK relaxation for all nine directions in parallel
  dist_t res;

  lbm_collide #(.FRACTION_BITS(FRACTION_BITS)) u_collide (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_valid), .in_cell(v_cell), .ux(v_ux), .uy(v_uy),
    .relax_rate(relax_rate),
    .out_valid(out_valid), .res(res),
    .rho(density), .vel_x(velocity_x), .vel_y(velocity_y)
  );

  assign out_rest      = res[0];
  assign out_east      = res[1];
  assign out_north     = res[2];
  assign out_west      = res[3];
  assign out_south     = res[4];
  assign out_northeast = res[5];
  assign out_northwest = res[6];
  assign out_southwest = res[7];
  assign out_southeast = res[8];

endmodule

/* rtl/core/lbm_moments.sv */
module lbm_moments (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  lbm_pkg::dist_t  f,
  output logic            out_valid,
  output lbm_pkg::cell_t  out_cell,
  output lbm_pkg::moment_t mx,
  output lbm_pkg::moment_t my
);
  import lbm_pkg::*;

  logic    v1;
  dist_t   f1;
  moment_t sum1, mx1, my1;
  moment_t sum_c, mx_c, my_c;
  moment_t e [NUM_DIR];

  always_comb begin
    for (int k = 0; k < NUM_DIR; k++) begin
      e[k] = moment_t'($signed(f[k]));
    end
    sum_c = e[0] + e[1] + e[2] + e[3] + e[4] + e[5] + e[6] + e[7] + e[8];
    mx_c  = e[1] - e[3] + e[5] - e[6] - e[7] + e[8];
    my_c  = e[2] - e[4] + e[5] + e[6] - e[7] - e[8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1   <= f;
      sum1 <= sum_c;
      mx1  <= mx_c;
      my1  <= my_c;
      out_cell.f   <= f1;
      out_cell.rho <= sat_word(64'(sum1));
      mx <= mx1;
      my <= my1;
    end
  end

endmodule

/* rtl/core/lbm_div_lane.sv */
module lbm_div_lane #(
  parameter int FRACTION_BITS = lbm_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  lbm_pkg::moment_t num,
  input  lbm_pkg::word_t   den,
  output lbm_pkg::word_t   quot
);
  import lbm_pkg::*;

  // (num << FRACTION_BITS) / den, truncated toward zero, saturated
  logic [QUOT_W-1:0] rem [QUOT_W+1];
  logic [QUOT_W-1:0] nl  [QUOT_W+1];
  logic [QUOT_W-1:0] qq  [QUOT_W+1];
  logic [QUOT_W-1:0] dv  [QUOT_W+1];
  logic              ng  [QUOT_W+1];
  logic              ov  [QUOT_W+1];

  logic [SUM_W-1:0]  a;
  logic [QUOT_W-1:0] b;
  logic [67:0]       n;
  logic [47:0]       b_sh;

  always_comb begin
    a = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    b = den[WORD_W-1] ? QUOT_W'(-den) : QUOT_W'(den);
    n = 68'(a) << FRACTION_BITS;
    b_sh = 48'(b) << (QUOT_W - FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n[63:32];
      nl[0]  <= n[31:0];
      qq[0]  <= '0;
      dv[0]  <= b;
      ng[0]  <= num[SUM_W-1] ^ den[WORD_W-1];
      ov[0]  <= 48'(a) >= b_sh;
    end
  end

  for (genvar s = 0; s < QUOT_W; s++) begin : g_step
    logic [QUOT_W:0] t;
    logic            ge;
    always_comb begin
      t  = {rem[s], nl[s][QUOT_W-1]};
      ge = t >= {1'b0, dv[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? QUOT_W'(t - {1'b0, dv[s]}) : t[QUOT_W-1:0];
        nl[s+1]  <= nl[s] << 1;
        qq[s+1]  <= {qq[s][QUOT_W-2:0], ge};
        dv[s+1]  <= dv[s];
        ng[s+1]  <= ng[s];
        ov[s+1]  <= ov[s];
      end
    end
  end

  logic [QUOT_W-1:0] limit, mag;
  always_comb begin
    limit = ng[QUOT_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = (ov[QUOT_W] || qq[QUOT_W] > limit) ? limit : qq[QUOT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= ng[QUOT_W] ? word_t'(32'd0 - mag) : word_t'(mag);
    end
  end

endmodule

/* rtl/core/lbm_velocity.sv */
module lbm_velocity #(
  parameter int FRACTION_BITS = lbm_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  lbm_pkg::cell_t   in_cell,
  input  lbm_pkg::moment_t mx,
  input  lbm_pkg::moment_t my,
  output logic             out_valid,
  output lbm_pkg::cell_t   out_cell,
  output lbm_pkg::word_t   ux,
  output lbm_pkg::word_t   uy
);
  import lbm_pkg::*;

  logic  vs [LANE_LAT];
  cell_t cs [LANE_LAT];
  word_t qx, qy;

  lbm_div_lane #(.FRACTION_BITS(FRACTION_BITS)) u_div_x (
    .clk(clk), .en(en), .num(mx), .den(in_cell.rho), .quot(qx)
  );
  lbm_div_lane #(.FRACTION_BITS(FRACTION_BITS)) u_div_y (
    .clk(clk), .en(en), .num(my), .den(in_cell.rho), .quot(qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LANE_LAT; s++) vs[s] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
      for (int s = 1; s < LANE_LAT; s++) vs[s] <= vs[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs[0] <= in_cell;
      for (int s = 1; s < LANE_LAT; s++) cs[s] <= cs[s-1];
    end
  end

  // zero density: velocities forced to zero
  always_comb begin
    out_valid = vs[LANE_LAT-1];
    out_cell  = cs[LANE_LAT-1];
    ux = (out_cell.rho == '0) ? '0 : qx;
    uy = (out_cell.rho == '0) ? '0 : qy;
  end

endmodule

/* rtl/core/lbm_collide.sv */
module lbm_collide #(
  parameter int FRACTION_BITS = lbm_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  lbm_pkg::cell_t               in_cell,
  input  lbm_pkg::word_t               ux,
  input  lbm_pkg::word_t               uy,
  input  logic [lbm_pkg::RATE_W-1:0]   relax_rate,
  output logic                         out_valid,
  output lbm_pkg::dist_t               res,
  output lbm_pkg::word_t               rho,
  output lbm_pkg::word_t               vel_x,
  output lbm_pkg::word_t               vel_y
);
  import lbm_pkg::*;

  localparam int NST = 8;
  localparam int EU2_W = 63 - FRACTION_BITS;
  localparam int UU_W = 64 - FRACTION_BITS;
  localparam int DIFF_W = WORD_W + 1;
  localparam int DIR_X [NUM_DIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NUM_DIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam logic signed [63:0] W_REST = 64'(((64'd4 << FRACTION_BITS) + 64'd4) / 64'd9);
  localparam logic signed [63:0] W_AXIS = 64'(((64'd1 << FRACTION_BITS) + 64'd4) / 64'd9);
  localparam logic signed [63:0] W_DIAG = 64'(((64'd1 << FRACTION_BITS) + 64'd18) / 64'd36);
  localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRACTION_BITS;

  logic  vs  [NST];
  cell_t cs  [NST];
  word_t uxs [NST];
  word_t uys [NST];

  word_t                    eu1   [NUM_DIR];
  logic signed [63:0]       sqx1, sqy1;
  word_t                    eu2   [NUM_DIR];
  logic [EU2_W-1:0]         esq2  [NUM_DIR];
  logic [UU_W-1:0]          uu2;
  word_t                    poly3 [NUM_DIR];
  logic signed [63:0]       prod4 [NUM_DIR];
  logic signed [63:0]       pw5   [NUM_DIR];
  logic signed [DIFF_W-1:0] diff6 [NUM_DIR];
  logic signed [63:0]       pr7   [NUM_DIR];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NST; s++) vs[s] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
      for (int s = 1; s < NST; s++) vs[s] <= vs[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs[0]  <= in_cell;
      uxs[0] <= ux;
      uys[0] <= uy;
      for (int s = 1; s < NST; s++) begin
        cs[s]  <= cs[s-1];
        uxs[s] <= uxs[s-1];
        uys[s] <= uys[s-1];
      end
    end
  end

  for (genvar k = 0; k < NUM_DIR; k++) begin : g_dir
    localparam logic signed [63:0] W = (k == 0) ? W_REST : ((k < 5) ? W_AXIS : W_DIAG);
    logic signed [63:0] ex, ey, p2, t3, t9, tu, pl, rp, fk;

    always_comb begin
      ex = (DIR_X[k] == 1) ? 64'(ux) : ((DIR_X[k] == -1) ? -64'(ux) : 64'sd0);
      ey = (DIR_Y[k] == 1) ? 64'(uy) : ((DIR_Y[k] == -1) ? -64'(uy) : 64'sd0);
      p2 = 64'(eu1[k]) * 64'(eu1[k]);
      t3 = 64'(eu2[k]) * 64'sd3;
      t9 = $signed((64'(esq2[k]) * 64'd9) >> 1);
      tu = $signed((64'(uu2) * 64'd3) >> 1);
      pl = ONE_FX + t3 + t9 - tu;
      rp = 64'(sat_word(prod4[k] >>> FRACTION_BITS));
      fk = 64'($signed(cs[4].f[k]));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        eu1[k]   <= sat_word(ex + ey);
        eu2[k]   <= eu1[k];
        esq2[k]  <= EU2_W'(p2 >> FRACTION_BITS);
        poly3[k] <= sat_word(pl);
        prod4[k] <= 64'(cs[2].rho) * 64'(poly3[k]);
        pw5[k]   <= rp * W;
        diff6[k] <= DIFF_W'((pw5[k] >>> FRACTION_BITS) - fk);
        pr7[k]   <= 64'(diff6[k]) * $signed({34'd0, relax_rate});
        res[k]   <= sat_word(64'($signed(cs[6].f[k])) + (pr7[k] >>> FRACTION_BITS));
      end
    end
  end

  logic [63:0] sq_sum;
  always_comb sq_sum = 64'(sqx1) + 64'(sqy1);

  always_ff @(posedge clk) begin
    if (en) begin
      sqx1 <= 64'(ux) * 64'(ux);
      sqy1 <= 64'(uy) * 64'(uy);
      uu2  <= UU_W'(sq_sum >> FRACTION_BITS);
    end
  end

  always_comb begin
    out_valid = vs[NST-1];
    rho   = cs[NST-1].rho;
    vel_x = uxs[NST-1];
    vel_y = uys[NST-1];
  end

endmodule
